FILE: rtl/ldh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ldh_pkg;

  localparam int CountWidth = 32;
  localparam int NumBins    = 10;
  localparam int OutWidth   = 32;
  localparam int MantWidth  = 53;
  localparam int ExpWidth   = 12;
  localparam int PowWidth   = 68;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_OOR,
    CLS_SMALL,
    CLS_BIG
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_FRAC,
    ST_SCALE,
    ST_SUB,
    ST_DIGIT,
    ST_DUMP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic frac_step;
    logic frac_take;
    logic scale_step;
    logic sub_step;
    logic emit_digit;
    logic emit_bin;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    cls_e cls;
    logic frac_ge1;
    logic scale_more;
    logic sub_more;
    logic last;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/leading_digit_histogram.sv
// Zero and out-of-range samples go from the dispatch state straight to the digit state.
// Magnitudes below 1 are multiplied by ten (up to about 324 steps) until they reach 1, then floored.
// Magnitudes of 1 or more raise a power of ten up to the value, then subtract it to count the digit.
// One sample at a time; a last sample adds ten bin beats, one per cycle when not stalled.
// Reset (rst_ni low, asynchronous) clears the controller, the output beat and all bins.
`timescale 1ns / 1ps
`default_nettype none
module leading_digit_histogram (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // [63:0] sample_bits
  input  wire         s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] digit, [35:4] bin_count, [36] out_of_range
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // last_result
);
  import ldh_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [3:0]  out_digit;
  logic [31:0] out_count;
  logic        out_oor;

  ldh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ldh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .sample_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_digit_o (out_digit),
    .out_count_o (out_count),
    .out_oor_o   (out_oor),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, out_oor, out_count, out_digit};

`ifndef SYNTH
  // a beat is only loaded when the output slot is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_digit || cmd.emit_bin) |-> stat.out_free)
    else $error("beat loaded over a pending beat");

  // no new sample while the output still carries an unfinished dump
  a_no_accept_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser && !m_axis_tlast) |-> !s_axis_tready)
    else $error("sample accepted during bin dump");

  // out-of-range digit beats carry digit zero
  a_oor_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_oor) |-> (out_digit == 4'd0 && !m_axis_tuser))
    else $error("out-of-range beat with nonzero digit");

  // digits never exceed nine
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_digit <= 4'd9))
    else $error("digit above nine");
`endif

endmodule
`default_nettype wire

FILE: rtl/ldh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ldh_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  ldh_pkg::stat_t stat_i,
  output ldh_pkg::cmd_t  cmd_o
);
  import ldh_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        case (stat_i.cls)
          CLS_SMALL: state_d = ST_FRAC;
          CLS_BIG:   state_d = ST_SCALE;
          default:   state_d = ST_DIGIT;
        endcase
      end
      ST_FRAC: begin
        if (stat_i.frac_ge1) begin
          cmd_o.frac_take = 1'b1;
          state_d         = ST_DIGIT;
        end else begin
          cmd_o.frac_step = 1'b1;
        end
      end
      ST_SCALE: begin
        if (stat_i.scale_more) begin
          cmd_o.scale_step = 1'b1;
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        if (stat_i.sub_more) begin
          cmd_o.sub_step = 1'b1;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          state_d          = stat_i.last ? ST_DUMP : ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_bin = 1'b1;
          if (stat_i.idx_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ldh_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ldh_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ldh_pkg::cmd_t       cmd_i,
  output ldh_pkg::stat_t      stat_o,
  input  wire [63:0]          sample_i,
  input  wire                 last_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                out_kind_o,
  output logic [3:0]          out_digit_o,
  output logic [31:0]         out_count_o,
  output logic                out_oor_o,
  output logic                out_last_o
);
  import ldh_pkg::*;

  cls_e                  cls_q, cls_d;
  logic [MantWidth-1:0]  m_q;
  logic [ExpWidth-1:0]   e_q;
  logic [63:0]           v_q;
  logic [PowWidth-1:0]   p_q;
  logic [3:0]            dig_q;
  logic                  last_q;
  logic [3:0]            idx_q;
  logic [CountWidth-1:0] bins_q [NumBins];

  // sample classification and unpacking
  logic [10:0]          ex;
  logic [51:0]          fr;
  logic [MantWidth-1:0] m_in;
  logic [ExpWidth-1:0]  e_in;
  logic [5:0]           int_sh;
  logic [63:0]          int_in;

  always_comb begin
    ex     = sample_i[62:52];
    fr     = sample_i[51:0];
    m_in   = (ex == 11'd0) ? {1'b0, fr} : {1'b1, fr};
    e_in   = (ex == 11'd0) ? -12'sd1074 : ExpWidth'({1'b0, ex} - 12'd1075);
    int_sh = 6'(11'd1086 - ex);
    int_in = {m_in, 11'd0} >> int_sh;
    if (sample_i[62:0] == 63'd0) begin
      cls_d = CLS_ZERO;
    end else if (ex >= 11'h43F) begin
      cls_d = CLS_OOR;
    end else if (ex < 11'd1023) begin
      cls_d = CLS_SMALL;
    end else begin
      cls_d = CLS_BIG;
    end
  end

  // multiply by ten with round to nearest even
  logic [56:0]          prod;
  logic [2:0]           sh;
  logic [56:0]          kept;
  logic [56:0]          rem;
  logic [56:0]          half;
  logic                 up;
  logic [MantWidth:0]   rnd;
  logic [MantWidth-1:0] m_nx;
  logic [ExpWidth-1:0]  e_nx;

  always_comb begin
    prod = ({4'd0, m_q} << 3) + ({4'd0, m_q} << 1);
    if (prod[56])      sh = 3'd4;
    else if (prod[55]) sh = 3'd3;
    else if (prod[54]) sh = 3'd2;
    else if (prod[53]) sh = 3'd1;
    else               sh = 3'd0;
    kept = prod >> sh;
    rem  = prod & ((57'd1 << sh) - 57'd1);
    half = (sh == 3'd0) ? 57'd0 : (57'd1 << (sh - 3'd1));
    up   = (sh != 3'd0) && ((rem > half) || ((rem == half) && kept[0]));
    rnd  = kept[MantWidth:0] + {{MantWidth{1'b0}}, up};
    if (rnd[MantWidth]) begin
      m_nx = {1'b1, {(MantWidth-1){1'b0}}};
      e_nx = e_q + ExpWidth'(sh) + 12'd1;
    end else begin
      m_nx = rnd[MantWidth-1:0];
      e_nx = e_q + ExpWidth'(sh);
    end
  end

  // floor of a value in [1, 16)
  logic                 ge1;
  logic [5:0]           fl_sh;
  logic [MantWidth-1:0] fl;
  logic [3:0]           fl_dig;

  always_comb begin
    ge1    = m_q[MantWidth-1] && ($signed(e_q) >= -12'sd52);
    fl_sh  = 6'(-e_q);
    fl     = m_q >> fl_sh;
    fl_dig = (fl > 53'd9) ? 4'd9 : fl[3:0];
  end

  // power of ten search for integer magnitudes
  logic [PowWidth-1:0] p10;
  assign p10 = (p_q << 3) + (p_q << 1);

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q    <= m_in;
      e_q    <= e_in;
      v_q    <= int_in;
      p_q    <= PowWidth'(1);
      dig_q  <= 4'd0;
      last_q <= last_i;
    end
    if (cmd_i.frac_step) begin
      m_q <= m_nx;
      e_q <= e_nx;
    end
    if (cmd_i.frac_take) begin
      dig_q <= fl_dig;
    end
    if (cmd_i.scale_step) begin
      p_q <= p10;
    end
    if (cmd_i.sub_step) begin
      v_q   <= v_q - p_q[63:0];
      dig_q <= dig_q + 4'd1;
    end
  end

  // class and dump index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= CLS_ZERO;
      idx_q <= 4'd0;
    end else begin
      if (cmd_i.load) begin
        cls_q <= cls_d;
      end
      if (cmd_i.emit_digit) begin
        idx_q <= 4'd0;
      end else if (cmd_i.emit_bin) begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  // saturating bins, all cleared when the last bin beat is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBins; i++) bins_q[i] <= '0;
    end else begin
      for (int i = 0; i < NumBins; i++) begin
        if (cmd_i.emit_bin && idx_q == 4'(NumBins - 1)) begin
          bins_q[i] <= '0;
        end else if (cmd_i.emit_digit && cls_q != CLS_OOR &&
                     dig_q == 4'(i) && bins_q[i] != '1) begin
          bins_q[i] <= bins_q[i] + 1'b1;
        end
      end
    end
  end

  // output register
  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_digit || cmd_i.emit_bin) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_digit) begin
      out_kind_o  <= 1'b0;
      out_digit_o <= dig_q;
      out_count_o <= '0;
      out_oor_o   <= (cls_q == CLS_OOR);
      out_last_o  <= !last_q;
    end else if (cmd_i.emit_bin) begin
      out_kind_o  <= 1'b1;
      out_digit_o <= idx_q;
      out_count_o <= OutWidth'(bins_q[idx_q]);
      out_oor_o   <= 1'b0;
      out_last_o  <= (idx_q == 4'(NumBins - 1));
    end
  end

  // status
  always_comb begin
    stat_o.cls        = cls_q;
    stat_o.frac_ge1   = ge1;
    stat_o.scale_more = (p10 <= {4'd0, v_q});
    stat_o.sub_more   = ({4'd0, v_q} >= p_q);
    stat_o.last       = last_q;
    stat_o.idx_last   = (idx_q == 4'(NumBins - 1));
    stat_o.out_free   = out_free;
  end

endmodule
`default_nettype wire
